// ===== rtl/core/swrm_pkg.sv =====
// ----------------------------------------------------------------------------
// swrm_pkg
// shared widths, constants and codes of the sliding window rate meter
// ----------------------------------------------------------------------------
package swrm_pkg;

    // ring depth default
    localparam int DEPTH_DEF = 64;

    // field widths
    localparam int BYTES_W = 31;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 31;
    localparam int HELD_W  = 7;

    // microseconds per second and its width
    localparam int            USEC_W       = 20;
    localparam logic [19:0]   USEC_PER_SEC = 20'd1000000;

    // largest reported rate
    localparam logic [30:0]   RATE_MAX = 31'h7fff_ffff;

    // configuration port
    localparam int            PADDR_W      = 3;
    localparam int            PDATA_W      = 32;
    localparam logic          REG_MAX_AGE  = 1'b0;
    localparam logic [31:0]   MAX_AGE_RST  = 32'd10000000;

    // shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

// ===== rtl/core/swrm_ifs.sv =====
// ----------------------------------------------------------------------------
// swrm sample and result channels
// valid/ready channels that carry one traffic sample and one rate result
// ----------------------------------------------------------------------------
interface swrm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [swrm_pkg::BYTES_W-1:0]  sample_bytes;
    logic [swrm_pkg::TIME_W-1:0]   sample_time;

    modport source (output valid, output sample_bytes, output sample_time, input ready);
    modport sink   (input valid, input sample_bytes, input sample_time, output ready);
endinterface

interface swrm_result_if;
    logic                          valid;
    logic                          ready;
    logic [swrm_pkg::RATE_W-1:0]   rate;
    logic [swrm_pkg::HELD_W-1:0]   samples_held;

    modport source (output valid, output rate, output samples_held, input ready);
    modport sink   (input valid, input rate, input samples_held, output ready);
endinterface

// ===== rtl/core/swrm_cfg.sv =====
// ----------------------------------------------------------------------------
// swrm_cfg
// apb register slave holding the max age limit
// ----------------------------------------------------------------------------
module swrm_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swrm_pkg::PADDR_W-1:0]  paddr,
    input  logic [swrm_pkg::PDATA_W-1:0]  pwdata,
    output logic [swrm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [swrm_pkg::TIME_W-1:0]   max_age
);

    logic [swrm_pkg::TIME_W-1:0] max_age_reg;
    logic [swrm_pkg::TIME_W-1:0] max_age_next;
    logic                        sel_max_age;

    // word index sits above the byte offset
    assign sel_max_age = (paddr[2] == swrm_pkg::REG_MAX_AGE);
    assign pready      = 1'b1;

    always_comb
    begin
        max_age_next = max_age_reg;
        if (psel && penable && pwrite && pready && sel_max_age)
        begin
            max_age_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= swrm_pkg::MAX_AGE_RST;
        end
        else
        begin
            max_age_reg <= max_age_next;
        end
    end

    assign prdata  = sel_max_age ? max_age_reg : '0;
    assign max_age = max_age_reg;

endmodule

// ===== rtl/core/swrm_ring.sv =====
// ----------------------------------------------------------------------------
// swrm_ring
// sample store, one write port and one registered read port
// ----------------------------------------------------------------------------
module swrm_ring
#(
    parameter int DEPTH = swrm_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [IW-1:0]                 wr_addr,
    input  logic [swrm_pkg::BYTES_W-1:0]  wr_bytes,
    input  logic [swrm_pkg::TIME_W-1:0]   wr_time,
    input  logic [IW-1:0]                 rd_addr,
    output logic [swrm_pkg::BYTES_W-1:0]  rd_bytes,
    output logic [swrm_pkg::TIME_W-1:0]   rd_time
);

    localparam int EW = swrm_pkg::BYTES_W + swrm_pkg::TIME_W;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_bytes, wr_time};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_bytes = rd_data_reg[EW-1:swrm_pkg::TIME_W];
    assign rd_time  = rd_data_reg[swrm_pkg::TIME_W-1:0];

endmodule

// ===== rtl/core/swrm_alu.sv =====
// ----------------------------------------------------------------------------
// swrm_alu
// shared wide adder / subtractor with carry out
// ----------------------------------------------------------------------------
module swrm_alu
#(
    parameter int W = 57
)
(
    input  logic              [W-1:0] a,
    input  logic              [W-1:0] b,
    input  swrm_pkg::alu_op_t         op,
    output logic              [W-1:0] sum,
    output logic                      carry
);

    logic [W-1:0] b_eff;
    logic         cin;

    // carry set on subtract means a >= b
    assign cin   = (op == swrm_pkg::ALU_SUB);
    assign b_eff = cin ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, cin};

endmodule

// ===== rtl/core/sliding_window_rate_meter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_core
// byte rate over a sliding window of timestamped traffic samples
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  smp     | in  | valid / ready      | sample_bytes[30:0] sample_time[31:0]
//  res     | out | valid / ready      | rate[30:0] samples_held[6:0]
//  apb     | in  | psel/penable/pready| max_age at byte address 0
//
//  a request is accepted only in idle, then runs store, read, check, 20
//  multiply steps, overflow test, 32 divide steps and hand-off; multiply,
//  test and divide share the one adder, and each purged entry repeats read
//  and check. zero total ends at store or check, zero span at check, overflow
//  at the test. reset covers control state, counts, total and max_age only.
//  the hand-off cycle waits while the output register holds an unread result
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_core
#(
    parameter int DEPTH = swrm_pkg::DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    swrm_sample_if.sink                   smp,
    swrm_result_if.source                 res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swrm_pkg::PADDR_W-1:0]  paddr,
    input  logic [swrm_pkg::PDATA_W-1:0]  pwdata,
    output logic [swrm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // ring index, held count and running total widths
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = swrm_pkg::BYTES_W + CW;
    // numerator width: total times one million
    localparam int NW = TW + swrm_pkg::USEC_W;

    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [4:0]    MUL_LAST  = 5'(swrm_pkg::USEC_W - 1);
    localparam logic [4:0]    DIV_LAST  = 5'd31;
    localparam logic [31:0]   USEC_PAD  = 32'(swrm_pkg::USEC_PER_SEC);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_STORE = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_CHECK = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_SAT   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // sequencer and window state
    state_t                        state_reg,    state_next;
    logic [IW-1:0]                 oldest_reg,   oldest_next;
    logic [IW-1:0]                 newest_reg,   newest_next;
    logic [CW-1:0]                 held_reg,     held_next;
    logic [TW-1:0]                 total_reg,    total_next;
    logic [4:0]                    cnt_reg,      cnt_next;
    // request and arithmetic working registers
    logic [swrm_pkg::BYTES_W-1:0]  bytes_reg,    bytes_next;
    logic [swrm_pkg::TIME_W-1:0]   now_reg,      now_next;
    logic [31:0]                   elapsed_reg,  elapsed_next;
    logic [NW-1:0]                 acc_reg,      acc_next;
    logic [31:0]                   rem_reg,      rem_next;
    logic [31:0]                   low_reg,      low_next;
    logic [swrm_pkg::RATE_W-1:0]   rate_reg,     rate_next;
    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [swrm_pkg::RATE_W-1:0]   out_rate_reg,  out_rate_next;
    logic [swrm_pkg::HELD_W-1:0]   out_held_reg,  out_held_next;

    logic                          accept;
    logic                          out_load;
    logic [swrm_pkg::TIME_W-1:0]   max_age;
    logic [swrm_pkg::BYTES_W-1:0]  rd_bytes;
    logic [swrm_pkg::TIME_W-1:0]   rd_time;
    logic                          wr_en;
    logic [swrm_pkg::TIME_W-1:0]   age;
    logic [NW-1:0]                 alu_a;
    logic [NW-1:0]                 alu_b;
    swrm_pkg::alu_op_t             alu_op;
    logic [NW-1:0]                 alu_sum;
    logic                          alu_carry;
    logic [31:0]                   quo;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    swrm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_age (max_age)
    );

    // ------------------------------------------------------------------
    // sample ring, always reading the oldest slot
    // ------------------------------------------------------------------
    swrm_ring #(.DEPTH(DEPTH), .IW(IW)) u_ring
    (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (newest_next),
        .wr_bytes (bytes_reg),
        .wr_time  (now_reg),
        .rd_addr  (oldest_reg),
        .rd_bytes (rd_bytes),
        .rd_time  (rd_time)
    );

    // ------------------------------------------------------------------
    // shared adder: multiply steps, saturation test, divide steps
    // ------------------------------------------------------------------
    swrm_alu #(.W(NW)) u_alu
    (
        .a     (alu_a),
        .b     (alu_b),
        .op    (alu_op),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = swrm_pkg::ALU_ADD;
        unique case (state_reg)
            ST_MUL:
            begin
                // msb first: acc = 2*acc + bit*total
                alu_a  = {acc_reg[NW-2:0], 1'b0};
                alu_b  = USEC_PAD[cnt_reg] ? NW'(total_reg) : '0;
                alu_op = swrm_pkg::ALU_ADD;
            end
            ST_SAT:
            begin
                // quotient overflows 32 bits when high word >= elapsed
                alu_a  = NW'(acc_reg[NW-1:32]);
                alu_b  = NW'(elapsed_reg);
                alu_op = swrm_pkg::ALU_SUB;
            end
            ST_DIV:
            begin
                alu_a  = NW'({rem_reg, low_reg[31]});
                alu_b  = NW'(elapsed_reg);
                alu_op = swrm_pkg::ALU_SUB;
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = swrm_pkg::ALU_ADD;
            end
        endcase
    end

    assign accept   = smp.valid && smp.ready;
    assign smp.ready = (state_reg == ST_IDLE);
    assign age      = now_reg - rd_time;
    assign wr_en    = (state_reg == ST_STORE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);
    assign quo      = {low_reg[30:0], alu_carry};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        held_next    = held_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        bytes_next   = bytes_reg;
        now_next     = now_reg;
        elapsed_next = elapsed_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        rate_next    = rate_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bytes_next = smp.sample_bytes;
                    now_next   = smp.sample_time;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // ring read data holds the oldest entry here
                if (held_reg == '0)
                begin
                    oldest_next = '0;
                    newest_next = '0;
                    held_next   = CW'(1);
                    total_next  = TW'(bytes_reg);
                end
                else
                begin
                    newest_next = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
                    if (held_reg == FULL_CNT)
                    begin
                        // full ring: the oldest entry is overwritten
                        oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                        total_next  = total_reg - TW'(rd_bytes) + TW'(bytes_reg);
                    end
                    else
                    begin
                        held_next  = held_reg + 1'b1;
                        total_next = total_reg + TW'(bytes_reg);
                    end
                end
                if (total_next == '0)
                begin
                    rate_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // read of the current oldest slot in flight
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (held_reg == '0)
                begin
                    rate_next  = '0;
                    state_next = ST_DONE;
                end
                else if (age > max_age)
                begin
                    // stale entry leaves the window
                    total_next  = total_reg - TW'(rd_bytes);
                    oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                    held_next   = held_reg - 1'b1;
                    state_next  = ST_READ;
                end
                else if (total_reg == '0 || age == '0)
                begin
                    rate_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    elapsed_next = age;
                    acc_next     = '0;
                    cnt_next     = MUL_LAST;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = alu_sum;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (alu_carry)
                begin
                    rate_next  = swrm_pkg::RATE_MAX;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = 32'(acc_reg[NW-1:32]);
                    low_next   = acc_reg[31:0];
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring step, quotient bit shifts in at the bottom
                rem_next = alu_carry ? alu_sum[31:0] : {rem_reg[30:0], low_reg[31]};
                low_next = quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rate_next  = quo[31] ? swrm_pkg::RATE_MAX : quo[30:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rate_next  = out_rate_reg;
        out_held_next  = out_held_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_rate_next  = rate_reg;
            out_held_next  = swrm_pkg::HELD_W'(held_reg);
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            held_reg      <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            held_reg      <= held_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg    <= bytes_next;
        now_reg      <= now_next;
        elapsed_reg  <= elapsed_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        rate_reg     <= rate_next;
        out_rate_reg <= out_rate_next;
        out_held_reg <= out_held_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.rate         = out_rate_reg;
    assign res.samples_held = out_held_reg;

endmodule
